/* sv/pprs_pkg.sv */
// Shared types, widths and codes of the plane proximity run segmenter.
package pprs_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int NORMAL_WIDTH = 16;
    localparam int LIMIT_WIDTH  = 23;
    localparam int LIMIT_SHIFT  = NORMAL_WIDTH - 1;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = DIFF_W + NORMAL_WIDTH;
    localparam int DOT_W  = PROD_W + 2;
    localparam int CMP_W  = (DOT_W > LIMIT_WIDTH + LIMIT_SHIFT) ?
                            DOT_W : LIMIT_WIDTH + LIMIT_SHIFT;
    localparam int SQ_W   = 2 * NORMAL_WIDTH + 2;

    localparam int DATA_W  = 3 * COORD_WIDTH;
    localparam int TDATA_W = ((DATA_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COORD_WIDTH > LIMIT_WIDTH) ? COORD_WIDTH : LIMIT_WIDTH;

    localparam int NORMAL_MIN_SQ = 1074;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 3'd6;

    localparam logic [NORMAL_WIDTH-1:0] NORMAL_Z_RESET = 16'sd32767;
    localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET    = 23'd256;

    // result kinds
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_END   = 1'b1;

    typedef enum logic [1:0] {
        RUN_IDLE,
        RUN_ONE,
        RUN_STREAM
    } t_run_class;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] z;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] x;
    } t_point;

    // one input's worth of results: held point, current point, end marker
    typedef struct packed {
        logic   emit_held;
        logic   emit_point;
        logic   emit_end;
        t_point held;
        t_point point;
    } t_burst;

endpackage

/* sv/pprs_front.sv */
// Front end: config registers, plane distance pipeline and run classification.
module pprs_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pprs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pprs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    input  pprs_pkg::t_point                    i_point,
    input  logic                                i_last,
    output logic                                o_ready,
    input  logic                                i_full,
    output logic                                o_push,
    output pprs_pkg::t_burst                    o_burst
);

    localparam int CW = pprs_pkg::COORD_WIDTH;
    localparam int NW = pprs_pkg::NORMAL_WIDTH;

    logic signed [CW-1:0] r_org_x, r_org_y, r_org_z;
    logic signed [NW-1:0] r_nrm_x, r_nrm_y, r_nrm_z;
    logic [pprs_pkg::LIMIT_WIDTH-1:0] r_limit;
    logic r_norm_ok;
    logic signed [pprs_pkg::SQ_W-1:0] w_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_nrm_x <= '0;
            r_nrm_y <= '0;
            r_nrm_z <= pprs_pkg::NORMAL_Z_RESET;
            r_limit <= pprs_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pprs_pkg::CFG_ORIGIN_X:   r_org_x <= i_cfg_data[CW-1:0];
                pprs_pkg::CFG_ORIGIN_Y:   r_org_y <= i_cfg_data[CW-1:0];
                pprs_pkg::CFG_ORIGIN_Z:   r_org_z <= i_cfg_data[CW-1:0];
                pprs_pkg::CFG_NORMAL_X:   r_nrm_x <= i_cfg_data[NW-1:0];
                pprs_pkg::CFG_NORMAL_Y:   r_nrm_y <= i_cfg_data[NW-1:0];
                pprs_pkg::CFG_NORMAL_Z:   r_nrm_z <= i_cfg_data[NW-1:0];
                pprs_pkg::CFG_DIST_LIMIT: r_limit <= i_cfg_data[pprs_pkg::LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // degenerate normal check, refreshed every cycle from the registers
    assign w_sq = pprs_pkg::SQ_W'(r_nrm_x * r_nrm_x) + pprs_pkg::SQ_W'(r_nrm_y * r_nrm_y)
                + pprs_pkg::SQ_W'(r_nrm_z * r_nrm_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_ok <= 1'b1;
        end else begin
            r_norm_ok <= (w_sq >= pprs_pkg::SQ_W'(pprs_pkg::NORMAL_MIN_SQ));
        end
    end

    // whole pipeline stalls while the queue is full
    logic w_en;
    assign w_en    = !i_full;
    assign o_ready = w_en;

    // stage A: offsets and products
    logic signed [pprs_pkg::DIFF_W-1:0] w_dx, w_dy, w_dz;
    logic signed [pprs_pkg::PROD_W-1:0] r_px, r_py, r_pz;
    logic             r_a_valid, r_a_last, r_a_nz;
    pprs_pkg::t_point r_a_point;

    assign w_dx = $signed({i_point.x[CW-1], i_point.x}) - $signed({r_org_x[CW-1], r_org_x});
    assign w_dy = $signed({i_point.y[CW-1], i_point.y}) - $signed({r_org_y[CW-1], r_org_y});
    assign w_dz = $signed({i_point.z[CW-1], i_point.z}) - $signed({r_org_z[CW-1], r_org_z});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px      <= pprs_pkg::PROD_W'(w_dx) * pprs_pkg::PROD_W'(r_nrm_x);
            r_py      <= pprs_pkg::PROD_W'(w_dy) * pprs_pkg::PROD_W'(r_nrm_y);
            r_pz      <= pprs_pkg::PROD_W'(w_dz) * pprs_pkg::PROD_W'(r_nrm_z);
            r_a_point <= i_point;
            r_a_last  <= i_last;
            r_a_nz    <= |i_point;
        end
    end

    // stage B: dot product
    logic signed [pprs_pkg::DOT_W-1:0] r_dot;
    logic             r_b_valid, r_b_last, r_b_nz;
    pprs_pkg::t_point r_b_point;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dot     <= pprs_pkg::DOT_W'(r_px) + pprs_pkg::DOT_W'(r_py)
                       + pprs_pkg::DOT_W'(r_pz);
            r_b_point <= r_a_point;
            r_b_last  <= r_a_last;
            r_b_nz    <= r_a_nz;
        end
    end

    // classification: |dot| < limit * 2^15, all-zero point never near
    logic [pprs_pkg::DOT_W-1:0] w_mag;
    logic w_near, w_step;
    assign w_mag  = r_dot[pprs_pkg::DOT_W-1] ? pprs_pkg::DOT_W'(-r_dot)
                                             : pprs_pkg::DOT_W'(r_dot);
    assign w_near = r_b_nz && (pprs_pkg::CMP_W'(w_mag) <
                    (pprs_pkg::CMP_W'(r_limit) << pprs_pkg::LIMIT_SHIFT));
    assign w_step = r_b_valid && w_en;

    pprs_pkg::t_run_class r_class, n_class;
    pprs_pkg::t_point     r_held;
    logic w_emit_held, w_emit_point, w_emit_end;

    always_comb begin
        n_class = r_class;
        if (!r_norm_ok || r_b_last || !w_near) begin
            n_class = pprs_pkg::RUN_IDLE;
        end else begin
            case (r_class)
                pprs_pkg::RUN_IDLE:   n_class = pprs_pkg::RUN_ONE;
                pprs_pkg::RUN_ONE:    n_class = pprs_pkg::RUN_STREAM;
                pprs_pkg::RUN_STREAM: n_class = pprs_pkg::RUN_STREAM;
                default:              n_class = pprs_pkg::RUN_IDLE;
            endcase
        end
    end

    always_comb begin
        w_emit_held  = 1'b0;
        w_emit_point = 1'b0;
        w_emit_end   = 1'b0;
        case (r_class)
            pprs_pkg::RUN_ONE: begin
                w_emit_held  = w_near;
                w_emit_point = w_near;
                w_emit_end   = w_near && r_b_last;
            end
            pprs_pkg::RUN_STREAM: begin
                w_emit_point = w_near;
                w_emit_end   = !w_near || r_b_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class <= pprs_pkg::RUN_IDLE;
        end else if (w_step) begin
            r_class <= n_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && r_norm_ok && w_near && r_class == pprs_pkg::RUN_IDLE) begin
            r_held <= r_b_point;
        end
    end

    assign o_push             = w_step && r_norm_ok && (w_emit_held || w_emit_point || w_emit_end);
    assign o_burst.emit_held  = w_emit_held;
    assign o_burst.emit_point = w_emit_point;
    assign o_burst.emit_end   = w_emit_end;
    assign o_burst.held       = r_held;
    assign o_burst.point      = r_b_point;

endmodule

/* sv/pprs_queue.sv */
// Small burst queue between the front end and the output expander.
module pprs_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pprs_pkg::t_burst i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output pprs_pkg::t_burst o_head
);

    localparam int PW = pprs_pkg::QUEUE_PTR_W;

    pprs_pkg::t_burst r_mem [pprs_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;
    logic w_push, w_pop;

    assign o_full  = (r_count == (PW+1)'(pprs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/pprs_back.sv */
// Back end: expands each queued burst into result transfers.
module pprs_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  pprs_pkg::t_burst               i_head,
    output logic                           o_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [pprs_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast
);

    // bit 0 held point, bit 1 current point, bit 2 end marker
    logic [2:0] r_done, w_rem, w_sel, w_left;
    pprs_pkg::t_point w_pt;
    logic w_xfer;

    assign w_rem = {i_head.emit_end, i_head.emit_point, i_head.emit_held} & ~r_done;

    always_comb begin
        w_sel        = 3'b000;
        w_pt         = '0;
        m_axis_tuser = pprs_pkg::KIND_END;
        if (w_rem[0]) begin
            w_sel        = 3'b001;
            w_pt         = i_head.held;
            m_axis_tuser = pprs_pkg::KIND_POINT;
        end else if (w_rem[1]) begin
            w_sel        = 3'b010;
            w_pt         = i_head.point;
            m_axis_tuser = pprs_pkg::KIND_POINT;
        end else begin
            w_sel        = 3'b100;
        end
    end

    assign w_left        = w_rem & ~w_sel;
    assign m_axis_tvalid = i_valid;
    assign m_axis_tlast  = (w_left == 3'b000);
    assign m_axis_tdata  = pprs_pkg::TDATA_W'(w_pt);
    assign w_xfer        = m_axis_tvalid && m_axis_tready;
    assign o_pop         = w_xfer && m_axis_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else if (w_xfer) begin
            r_done <= m_axis_tlast ? 3'b000 : (r_done | w_sel);
        end
    end

endmodule

/* sv/plane_proximity_run_segmenter_top.sv */
// Top level of the plane proximity run segmenter.
//
// Takes one grid point per cycle (x, y, z in signed Q16.8) and tests its
// distance to the configured plane: |(p - origin) . normal| < limit, exact,
// no rounding. Near points build runs; a far or all-zero point, or tlast on
// the input, closes the run. Runs of two or more points come out point by
// point (tuser = 0) and end with a marker (tuser = 1, zero coordinates);
// single-point runs are dropped. m_axis_tlast flags the final result caused
// by one input point. A normal shorter than 0.001 suppresses all output.
// Rate: one input transfer per cycle while the queue is not full; a point
// passes the product stage, then the dot-product stage, with the run
// classification on the way into the queue. The output side delivers one
// result per cycle while m_axis_tready is high, and an input point can cause
// up to 3 results; a four-entry burst queue absorbs that, and the input
// stalls only while the queue is full. Config writes are taken any cycle but
// are meant for idle periods; a new normal is checked for length in a
// register fed from the normal registers.
module plane_proximity_run_segmenter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [pprs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pprs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // point stream in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pprs_pkg::TDATA_W-1:0]       s_axis_tdata,   // point_x, point_y, point_z
    input  logic                               s_axis_tlast,   // final_point
    // result stream out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pprs_pkg::TDATA_W-1:0]       m_axis_tdata,   // out_x, out_y, out_z
    output logic                               m_axis_tuser,   // item_kind
    output logic                               m_axis_tlast    // last_of_burst
);

    pprs_pkg::t_point w_in_point;
    pprs_pkg::t_burst w_push_data, w_head;
    logic w_push, w_full, w_pop, w_head_valid;

    // unpack: x in the lowest bits
    assign w_in_point = s_axis_tdata[pprs_pkg::DATA_W-1:0];

    pprs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_point    (w_in_point),
        .i_last     (s_axis_tlast),
        .o_ready    (s_axis_tready),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_burst    (w_push_data)
    );

    // bursts waiting for the output side
    pprs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    pprs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_head_valid),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
